/* hdl/lpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants for the Lagrange polynomial evaluator.
// ----------------------------------------------------------------------------
package lpe_pkg;

    localparam int VAL_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 65;
    localparam int ERR_W   = 2;
    localparam int CNT_W   = 5;

    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DUP  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SAT  = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUP_RD,
        ST_DUP_CMP,
        ST_TERM_INIT,
        ST_W_RD,
        ST_W_MUL,
        ST_W_DIV,
        ST_W_WAIT,
        ST_W_CLIP,
        ST_Y_RD,
        ST_Y_MUL,
        ST_Y_ACC,
        ST_FINISH,
        ST_OUT
    } lpe_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // store node word
        logic start_eval;   // latch query, clear sum and flags
        logic rd_ij;        // read x_i and x_j
        logic dup_chk;      // compare x_i and x_j
        logic term_init;    // weight = 1.0
        logic w_mul;        // product = weight * num
        logic div_start;    // launch divider
        logic w_clip;       // saturate quotient into weight
        logic rd_y;         // read y_i
        logic y_mul;        // product = weight * y_i
        logic y_acc;        // sum += shifted product
        logic finish;       // saturate sum into result
        logic out_valid;    // present result
    } lpe_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic dup_found;
        logic div_done;
        logic out_taken;
    } lpe_stat_t;

endpackage

/* hdl/lpe_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_divider
// Signed restoring divider, one quotient bit per cycle, quotient toward zero.
// ----------------------------------------------------------------------------
module lpe_divider
    import lpe_pkg::*;
#(
    parameter int NUM_W = 65,
    parameter int DEN_W = 33
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] numer,
    input  logic signed [DEN_W-1:0] denom,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic             neg_reg, neg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;

    // shift-subtract step
    always_comb
    begin
        trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, d_reg};
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = numer[NUM_W-1] ? NUM_W'(-numer) : numer;
            d_next    = denom[DEN_W-1] ? DEN_W'(-denom) : denom;
            neg_next  = numer[NUM_W-1] ^ denom[DEN_W-1];
            r_next    = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W+1])
            begin
                r_next = diff[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? NUM_W'(-q_reg) : q_reg;

endmodule

/* hdl/lpe_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_datapath
// Node memories, weight register, multiplier, divider and accumulator.
// ----------------------------------------------------------------------------
module lpe_datapath
    import lpe_pkg::*;
#(
    parameter int MAX_NODES = 16,
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lpe_cmd_t                cmd,
    output lpe_stat_t               stat,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic [IDX_W-1:0]        j_idx,
    input  logic [3:0]              node_index,
    input  logic signed [VAL_W-1:0] node_x,
    input  logic signed [VAL_W-1:0] node_y,
    input  logic signed [VAL_W-1:0] query_x,
    output logic signed [VAL_W-1:0] value,
    output logic [ERR_W-1:0]        error,
    input  logic                    out_ready
);

    // each term is at most 2^(2*VAL_W-2-FRAC_BITS); room for MAX_NODES of them
    localparam int SUM_W = 2 * VAL_W - FRAC_BITS + IDX_W + 1;
    localparam logic signed [PROD_W-1:0] S32MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] S32MIN = -PROD_W'(64'sd2147483648);

    logic signed [VAL_W-1:0] xmem [MAX_NODES];
    logic signed [VAL_W-1:0] ymem [MAX_NODES];

    logic signed [VAL_W-1:0]  xi_reg, xj_reg, yi_reg, q_reg, w_reg, res_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     sat_reg, dup_reg;
    logic [ERR_W-1:0]         err_reg;

    logic signed [DIFF_W-1:0] num, den;
    logic signed [PROD_W-1:0] quot, absp, shp;
    logic                     div_done;
    logic signed [PROD_W-1:0] sum_ext;

    // node memories: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load && ({1'b0, node_index} < 5'(MAX_NODES)))
        begin
            xmem[IDX_W'(node_index)] <= node_x;
            ymem[IDX_W'(node_index)] <= node_y;
        end
        if (cmd.rd_ij)
        begin
            xi_reg <= xmem[i_idx];
            xj_reg <= xmem[j_idx];
        end
        if (cmd.rd_y)
            yi_reg <= ymem[i_idx];
    end

    assign num = DIFF_W'(q_reg) - DIFF_W'(xj_reg);
    assign den = DIFF_W'(xi_reg) - DIFF_W'(xj_reg);

    lpe_divider #(.NUM_W(PROD_W), .DEN_W(DIFF_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (prod_reg),
        .denom (den),
        .done  (div_done),
        .quot  (quot)
    );

    // truncate toward zero on the right shift
    always_comb
    begin
        absp = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        shp  = absp >>> FRAC_BITS;
        if (prod_reg[PROD_W-1])
            shp = -shp;
        sum_ext = PROD_W'(sum_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_eval)
            q_reg <= query_x;
        if (cmd.term_init)
            w_reg <= VAL_W'(1) <<< FRAC_BITS;
        if (cmd.w_mul)
            prod_reg <= PROD_W'(w_reg) * PROD_W'(num);
        if (cmd.y_mul)
            prod_reg <= PROD_W'(w_reg) * PROD_W'(yi_reg);
        if (cmd.w_clip)
        begin
            if (quot > S32MAX)
                w_reg <= VAL_W'(S32MAX);
            else if (quot < S32MIN)
                w_reg <= VAL_W'(S32MIN);
            else
                w_reg <= VAL_W'(quot);
        end
    end

    // accumulator, flags and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
            dup_reg <= 1'b0;
            sum_reg <= '0;
            res_reg <= '0;
            err_reg <= ERR_NONE;
        end
        else
        begin
            if (cmd.start_eval)
            begin
                sat_reg <= 1'b0;
                dup_reg <= 1'b0;
                sum_reg <= '0;
            end
            if (cmd.dup_chk && (xi_reg == xj_reg))
                dup_reg <= 1'b1;
            if (cmd.w_clip && ((quot > S32MAX) || (quot < S32MIN)))
                sat_reg <= 1'b1;
            if (cmd.y_acc)
                sum_reg <= sum_reg + SUM_W'(shp);
            if (cmd.finish)
            begin
                if (dup_reg)
                begin
                    res_reg <= '0;
                    err_reg <= ERR_DUP;
                end
                else if (sum_ext > S32MAX)
                begin
                    res_reg <= VAL_W'(S32MAX);
                    err_reg <= ERR_SAT;
                end
                else if (sum_ext < S32MIN)
                begin
                    res_reg <= VAL_W'(S32MIN);
                    err_reg <= ERR_SAT;
                end
                else
                begin
                    res_reg <= VAL_W'(sum_reg);
                    err_reg <= sat_reg ? ERR_SAT : ERR_NONE;
                end
            end
        end
    end

    assign stat.dup_found = dup_reg;
    assign stat.div_done  = div_done;
    assign stat.out_taken = cmd.out_valid && out_ready;
    assign value = res_reg;
    assign error = err_reg;

endmodule

/* hdl/lpe_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_controller
// Sequencer over node pairs: duplicate scan, weight products, accumulation.
// ----------------------------------------------------------------------------
module lpe_controller
    import lpe_pkg::*;
#(
    parameter int MAX_NODES = 16,
    parameter int IDX_W     = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_func,
    output logic             in_ready,
    input  logic [CNT_W-1:0] node_count,
    input  lpe_stat_t        stat,
    output lpe_cmd_t         cmd,
    output logic [IDX_W-1:0] i_idx,
    output logic [IDX_W-1:0] j_idx
);

    lpe_state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, last_reg, last_next;
    logic i_last, j_last, skip;

    assign i_last = (i_reg == last_reg);
    assign j_last = (j_reg == last_reg);
    assign skip   = (j_reg == i_reg);

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_func == FUNC_EVAL))
                begin
                    if (node_count == '0)
                        last_next = '0;
                    else if (node_count > CNT_W'(MAX_NODES))
                        last_next = IDX_W'(MAX_NODES - 1);
                    else
                        last_next = IDX_W'(node_count - CNT_W'(1));
                    i_next = '0;
                    j_next = '0;
                    state_next = ST_DUP_RD;
                end
            end
            ST_DUP_RD:  state_next = ST_DUP_CMP;
            ST_DUP_CMP:
            begin
                if (j_last)
                begin
                    if (i_last)
                    begin
                        i_next = '0;
                        state_next = ST_TERM_INIT;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                        j_next = i_reg + IDX_W'(1);
                        state_next = ST_DUP_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                    state_next = ST_DUP_RD;
                end
            end
            ST_TERM_INIT:
            begin
                j_next = '0;
                state_next = stat.dup_found ? ST_FINISH : ST_W_RD;
            end
            ST_W_RD:
            begin
                if (skip)
                begin
                    if (j_last)
                        state_next = ST_Y_RD;
                    else
                        j_next = j_reg + IDX_W'(1);
                end
                else
                    state_next = ST_W_MUL;
            end
            ST_W_MUL:  state_next = ST_W_DIV;
            ST_W_DIV:  state_next = ST_W_WAIT;
            ST_W_WAIT: if (stat.div_done) state_next = ST_W_CLIP;
            ST_W_CLIP:
            begin
                if (j_last)
                    state_next = ST_Y_RD;
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                    state_next = ST_W_RD;
                end
            end
            ST_Y_RD:  state_next = ST_Y_MUL;
            ST_Y_MUL: state_next = ST_Y_ACC;
            ST_Y_ACC:
            begin
                if (i_last)
                    state_next = ST_FINISH;
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                    state_next = ST_TERM_INIT;
                end
            end
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (stat.out_taken) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // command decode
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && (in_func == FUNC_LOAD);
                cmd.start_eval = in_valid && (in_func == FUNC_EVAL);
            end
            ST_DUP_RD:    cmd.rd_ij = 1'b1;
            ST_DUP_CMP:   cmd.dup_chk = !skip;
            ST_TERM_INIT: cmd.term_init = 1'b1;
            ST_W_RD:      cmd.rd_ij = 1'b1;
            ST_W_MUL:     cmd.w_mul = 1'b1;
            ST_W_DIV:     cmd.div_start = 1'b1;
            ST_W_CLIP:    cmd.w_clip = 1'b1;
            ST_Y_RD:      cmd.rd_y = 1'b1;
            ST_Y_MUL:     cmd.y_mul = 1'b1;
            ST_Y_ACC:     cmd.y_acc = 1'b1;
            ST_FINISH:    cmd.finish = 1'b1;
            ST_OUT:       cmd.out_valid = 1'b1;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
        end
    end

    assign i_idx = i_reg;
    assign j_idx = j_reg;

endmodule

/* hdl/lagrange_polynomial_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_polynomial_evaluator
// Lagrange interpolation over a loaded node table, signed Q16.16, saturating.
//
// Channel   Direction  Contents
// s_axis    in         tdata: node_index, node_x, node_y, query_x; tuser: func
// m_axis    out        tdata: value, error
// cfg       in         node_count (5 bits)
//
// Load words are stored in the node table while idle. An evaluation first
// scans all node pairs for duplicate x values, then for each node builds
// its weight over the other nodes with the shared bit-serial divider (65
// steps a division) and adds weight times y to the sum. One item is worked
// at a time; input is held off until the result is taken.
// Reset is asynchronous; the node table is not cleared.
// ----------------------------------------------------------------------------
module lagrange_polynomial_evaluator
    import lpe_pkg::*;
#(
    parameter int MAX_NODES = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // node_index[3:0], node_x[35:4],
                                        // node_y[67:36], query_x[99:68]
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // value[31:0], error[33:32]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data       // node_count
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [CNT_W-1:0]        node_count_reg;
    lpe_cmd_t                cmd;
    lpe_stat_t               stat;
    logic [IDX_W-1:0]        i_idx, j_idx;
    logic signed [VAL_W-1:0] value;
    logic [ERR_W-1:0]        error;

    // node count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= CNT_W'(1);
        else if (cfg_valid)
            node_count_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    lpe_controller #(.MAX_NODES(MAX_NODES), .IDX_W(IDX_W)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_func    (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .node_count (node_count_reg),
        .stat       (stat),
        .cmd        (cmd),
        .i_idx      (i_idx),
        .j_idx      (j_idx)
    );

    lpe_datapath #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .i_idx      (i_idx),
        .j_idx      (j_idx),
        .node_index (s_axis_tdata[3:0]),
        .node_x     (s_axis_tdata[35:4]),
        .node_y     (s_axis_tdata[67:36]),
        .query_x    (s_axis_tdata[99:68]),
        .value      (value),
        .error      (error),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tvalid = cmd.out_valid;
    assign m_axis_tdata  = {6'd0, error, value};

endmodule
